FILE: rtl/core/sgl_pkg.sv
// ----------------------------------------------------------------------------
// sgl_pkg
// Shared types, codes and helpers of the scaled glyph line renderer.
// ----------------------------------------------------------------------------
package sgl_pkg;

  // request codes
  localparam logic [1:0] ReqDraw = 2'd0;
  localparam logic [1:0] ReqRead = 2'd1;
  localparam logic [1:0] ReqEnd  = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CfgFgColor = 2'd0;
  localparam logic [1:0] CfgBgColor = 2'd1;
  localparam logic [1:0] CfgScale   = 2'd2;

  localparam logic [15:0] FgReset    = 16'hFFFF;
  localparam logic [15:0] BgReset    = 16'h0000;
  localparam logic [7:0]  ScaleReset = 8'd16;

  // widest glyph row that is expanded, and the leftmost bit of a row
  localparam logic [4:0]  GlyphBits = 5'd16;
  localparam logic [15:0] LeftMask  = 16'h8000;

  // store address bits wide enough for the largest store
  localparam int unsigned StoreAddrW = 17;
  // width of a scaled coordinate, floor(k*s) with k up to 17
  localparam int unsigned ScaledW = 9;

  typedef struct packed {
    logic                  en;
    logic [StoreAddrW-1:0] addr;
    logic [15:0]           data;
  } sgl_wr_t;

  typedef struct packed {
    logic        start;
    logic        clear;
    logic [15:0] bits;
    logic [3:0]  row;
    logic [4:0]  width;
    logic [7:0]  xoff;
  } sgl_job_t;

  // floor(k*s) for a Q4.4 scale
  function automatic logic [ScaledW-1:0] scaled_floor(logic [4:0] k, logic [7:0] s);
    logic [12:0] prod;
    prod = 13'(k) * 13'(s);
    return prod[12:4];
  endfunction

endpackage

FILE: rtl/core/sgl_chan_if.sv
// ----------------------------------------------------------------------------
// sgl_req_if / sgl_rsp_if
// Request and response channels of the glyph line renderer.
// ----------------------------------------------------------------------------
interface sgl_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [15:0] row_bits;
  logic [3:0]  row_index;
  logic [4:0]  glyph_width;
  logic [7:0]  x_offset;
  logic [8:0]  start_row;
  logic [12:0] read_addr;

  modport source (
    output valid, req_type, row_bits, row_index, glyph_width, x_offset, start_row,
           read_addr,
    input  ready
  );
  modport sink (
    input  valid, req_type, row_bits, row_index, glyph_width, x_offset, start_row,
           read_addr,
    output ready
  );
endinterface

interface sgl_rsp_if;
  logic        valid;
  logic        ready;
  logic [15:0] pixel;
  logic [8:0]  latched_row;
  logic        was_active;

  modport source (
    output valid, pixel, latched_row, was_active,
    input  ready
  );
  modport sink (
    input  valid, pixel, latched_row, was_active,
    output ready
  );
endinterface

FILE: rtl/core/scaled_glyph_line_renderer_unit.sv
// ----------------------------------------------------------------------------
// scaled_glyph_line_renderer_unit
// Expands scaled one-bit glyph rows into a 16-bit pixel line store.
// ----------------------------------------------------------------------------
// read or end request: result registered from the read or end state once the response slot is free
// draw request: setup and base states, then each scaled row is written at one pixel a
//   cycle, with a step per glyph bit and per row between the pixels; one request is worked on at a time
// first draw after an end or after reset: all LINE_PIXELS*STORE_ROWS store words are
//   cleared first (7680 by default)
// reset: drawing inactive, held row zero, colors and scale at defaults, store undefined
module scaled_glyph_line_renderer_unit import sgl_pkg::*; #(
  parameter int unsigned LINE_PIXELS = 240,
  parameter int unsigned STORE_ROWS  = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  sgl_req_if.sink     req_i,
  sgl_rsp_if.source   rsp_o
);

  localparam int unsigned StoreWords = LINE_PIXELS * STORE_ROWS;
  localparam int unsigned AddrW      = $clog2(StoreWords);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StRead = 2'd1;
  localparam logic [1:0] StEnd  = 2'd2;
  localparam logic [1:0] StDraw = 2'd3;

  logic [1:0]  st_q, st_d;
  logic [15:0] fg_q, bg_q;
  logic [7:0]  scale_q;
  logic        active_q, active_d;
  logic [8:0]  held_row_q, held_row_d;
  logic        rd_ok_q;

  logic        rsp_valid_q, rsp_valid_d;
  logic [15:0] pixel_q, pixel_d;
  logic [8:0]  row_out_q, row_out_d;
  logic        was_act_q, was_act_d;

  logic        req_xfer, slot_free, rd_en, rd_in_range, rast_busy;
  logic [15:0] rd_data;
  sgl_job_t    job;
  sgl_wr_t     wr;

  assign req_xfer    = req_i.valid && req_i.ready;
  assign slot_free   = !rsp_valid_q || rsp_o.ready;
  assign rd_in_range = 32'(req_i.read_addr) < StoreWords;
  assign rd_en       = req_xfer && req_i.req_type == ReqRead;
  assign req_i.ready = st_q == StIdle;

  always_comb begin
    job.start = req_xfer && req_i.req_type == ReqDraw;
    job.clear = !active_q;
    job.bits  = req_i.row_bits;
    job.row   = req_i.row_index;
    job.width = req_i.glyph_width;
    job.xoff  = req_i.x_offset;
  end

  always_comb begin
    st_d        = st_q;
    active_d    = active_q;
    held_row_d  = held_row_q;
    rsp_valid_d = rsp_valid_q && !rsp_o.ready;
    pixel_d     = pixel_q;
    row_out_d   = row_out_q;
    was_act_d   = was_act_q;
    unique case (st_q)
      StIdle: begin
        if (req_xfer) begin
          case (req_i.req_type)
            ReqDraw: begin
              if (!active_q) begin
                active_d   = 1'b1;
                held_row_d = req_i.start_row;
              end
              st_d = StDraw;
            end
            ReqRead: st_d = StRead;
            ReqEnd:  st_d = StEnd;
            default: st_d = StIdle;
          endcase
        end
      end
      StRead: begin
        if (slot_free) begin
          rsp_valid_d = 1'b1;
          pixel_d     = rd_ok_q ? rd_data : 16'd0;
          row_out_d   = '0;
          was_act_d   = 1'b0;
          st_d        = StIdle;
        end
      end
      StEnd: begin
        if (slot_free) begin
          rsp_valid_d = 1'b1;
          pixel_d     = '0;
          row_out_d   = held_row_q;
          was_act_d   = active_q;
          active_d    = 1'b0;
          st_d        = StIdle;
        end
      end
      StDraw: begin
        if (!rast_busy) begin
          st_d = StIdle;
        end
      end
      default: st_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= StIdle;
      active_q    <= 1'b0;
      held_row_q  <= '0;
      rsp_valid_q <= 1'b0;
      fg_q        <= FgReset;
      bg_q        <= BgReset;
      scale_q     <= ScaleReset;
    end else begin
      st_q        <= st_d;
      active_q    <= active_d;
      held_row_q  <= held_row_d;
      rsp_valid_q <= rsp_valid_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CfgFgColor: fg_q    <= cfg_data_i;
          CfgBgColor: bg_q    <= cfg_data_i;
          CfgScale:   scale_q <= cfg_data_i[7:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pixel_q   <= pixel_d;
    row_out_q <= row_out_d;
    was_act_q <= was_act_d;
    if (rd_en) begin
      rd_ok_q <= rd_in_range;
    end
  end

  sgl_raster #(
    .LinePixels(LINE_PIXELS),
    .Depth     (StoreWords),
    .AddrW     (AddrW)
  ) u_raster (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .job_i  (job),
    .scale_i(scale_q),
    .fg_i   (fg_q),
    .bg_i   (bg_q),
    .busy_o (rast_busy),
    .wr_o   (wr)
  );

  sgl_line_store #(
    .Depth(StoreWords),
    .AddrW(AddrW)
  ) u_store (
    .clk_i    (clk_i),
    .wr_i     (wr),
    .rd_en_i  (rd_en),
    .rd_addr_i(AddrW'(req_i.read_addr)),
    .rd_data_o(rd_data)
  );

  assign rsp_o.valid       = rsp_valid_q;
  assign rsp_o.pixel       = pixel_q;
  assign rsp_o.latched_row = row_out_q;
  assign rsp_o.was_active  = was_act_q;

`ifndef SYNTH
  // a new request is never taken while the sequencer still writes
  assert property (@(posedge clk_i) disable iff (!rst_ni) req_i.ready |-> !rast_busy)
    else $error("request taken while raster busy");

  // the store is written only while a draw request is in progress
  assert property (@(posedge clk_i) disable iff (!rst_ni) wr.en |-> st_q == StDraw)
    else $error("store write outside a draw request");

  // a read transfer puts the block in its read state on the next cycle, where the registered store data is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni) rd_en |=> st_q == StRead)
    else $error("read request lost");
`endif

endmodule

FILE: rtl/core/sgl_line_store.sv
// ----------------------------------------------------------------------------
// sgl_line_store
// Pixel line store: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module sgl_line_store import sgl_pkg::*; #(
  parameter int unsigned Depth = 7680,
  parameter int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  sgl_wr_t          wr_i,
  input  logic             rd_en_i,
  input  logic [AddrW-1:0] rd_addr_i,
  output logic [15:0]      rd_data_o
);

  logic [15:0] mem [Depth];
  logic [15:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr[AddrW-1:0]] <= wr_i.data;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

FILE: rtl/core/sgl_raster.sv
// ----------------------------------------------------------------------------
// sgl_raster
// Write sequencer: clears the store when a job asks for it and expands one scaled glyph row.
// ----------------------------------------------------------------------------
module sgl_raster import sgl_pkg::*; #(
  parameter int unsigned LinePixels = 240,
  parameter int unsigned Depth      = 7680,
  parameter int unsigned AddrW      = $clog2(Depth)
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  sgl_job_t    job_i,
  input  logic [7:0]  scale_i,
  input  logic [15:0] fg_i,
  input  logic [15:0] bg_i,
  output logic        busy_o,
  output sgl_wr_t     wr_o
);

  // base plus column covers up to 256 rows of a line plus a scaled glyph
  localparam int unsigned BaseW = $clog2(256 * LinePixels + 1024);

  localparam logic [2:0] RIdle  = 3'd0;
  localparam logic [2:0] RClear = 3'd1;
  localparam logic [2:0] RSetup = 3'd2;
  localparam logic [2:0] RBase  = 3'd3;
  localparam logic [2:0] RDraw  = 3'd4;

  logic [2:0]         st_q, st_d;
  logic [AddrW-1:0]   clr_q, clr_d;
  logic [15:0]        bits_q;
  logic [3:0]         row_q;
  logic [4:0]         width_q;
  logic [7:0]         xoff_q;
  logic [ScaledW-1:0] y_q, y_d, yend_q, yend_d;
  logic [BaseW-1:0]   base_q, base_d;
  logic [4:0]         i_q, i_d;
  logic [ScaledW-1:0] x_q, x_d;

  logic [ScaledW-1:0] x_next_bit;
  logic [BaseW-1:0]   pix_addr;
  logic               row_left, bit_left, col_left, bit_set;

  assign x_next_bit = scaled_floor(i_q + 5'd1, scale_i);
  assign pix_addr   = base_q + BaseW'(x_q);
  assign row_left   = y_q < yend_q;
  assign bit_left   = i_q < width_q;
  assign col_left   = x_q < x_next_bit;
  assign bit_set    = |((bits_q << i_q[3:0]) & LeftMask);

  always_comb begin
    st_d   = st_q;
    clr_d  = clr_q;
    y_d    = y_q;
    yend_d = yend_q;
    base_d = base_q;
    i_d    = i_q;
    x_d    = x_q;
    wr_o   = '0;
    unique case (st_q)
      RIdle: begin
        if (job_i.start) begin
          clr_d = '0;
          st_d  = job_i.clear ? RClear : RSetup;
        end
      end
      RClear: begin
        wr_o.en   = 1'b1;
        wr_o.addr = StoreAddrW'(clr_q);
        wr_o.data = '0;
        clr_d     = clr_q + AddrW'(1);
        if (clr_q == AddrW'(Depth - 1)) begin
          st_d = RSetup;
        end
      end
      RSetup: begin
        y_d    = scaled_floor({1'b0, row_q}, scale_i);
        yend_d = scaled_floor({1'b0, row_q} + 5'd1, scale_i);
        st_d   = RBase;
      end
      RBase: begin
        base_d = BaseW'(y_q) * BaseW'(LinePixels) + BaseW'(xoff_q);
        i_d    = '0;
        x_d    = '0;
        st_d   = RDraw;
      end
      RDraw: begin
        if (!row_left) begin
          st_d = RIdle;
        end else if (!bit_left) begin
          y_d    = y_q + ScaledW'(1);
          base_d = base_q + BaseW'(LinePixels);
          i_d    = '0;
          x_d    = '0;
        end else if (!col_left) begin
          // span of this bit is done or empty
          i_d = i_q + 5'd1;
        end else begin
          wr_o.en   = pix_addr < BaseW'(Depth);
          wr_o.addr = StoreAddrW'(pix_addr);
          wr_o.data = bit_set ? fg_i : bg_i;
          x_d       = x_q + ScaledW'(1);
        end
      end
      default: st_d = RIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= RIdle;
    end else begin
      st_q <= st_d;
    end
  end

  always_ff @(posedge clk_i) begin
    clr_q  <= clr_d;
    y_q    <= y_d;
    yend_q <= yend_d;
    base_q <= base_d;
    i_q    <= i_d;
    x_q    <= x_d;
    if (st_q == RIdle && job_i.start) begin
      bits_q  <= job_i.bits;
      row_q   <= job_i.row;
      width_q <= (job_i.width > GlyphBits) ? GlyphBits : job_i.width;
      xoff_q  <= job_i.xoff;
    end
  end

  assign busy_o = st_q != RIdle;

endmodule

FILE: dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives glyph row, pixel read, end and spare-code requests into the line renderer and
// checks every response against a behavioral mirror of the line store or a directed value.
// ----------------------------------------------------------------------------
module testbench;
  import sgl_pkg::*;

  localparam int unsigned LinePixels = 240;
  localparam int unsigned StoreRows  = 32;
  localparam int unsigned StoreWords = LinePixels * StoreRows;
  localparam logic [1:0]  ReqSpare   = 2'd3;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] bits;
    logic [3:0]  row;
    logic [4:0]  width;
    logic [7:0]  xoff;
    logic [8:0]  start;
    logic [12:0] addr;
  } glyph_req_t;

  typedef struct packed {
    logic [15:0] pixel;
    logic [8:0]  row;
    logic        active;
  } glyph_rsp_t;

  typedef struct packed {
    glyph_req_t rq;
    logic       typed;
    glyph_rsp_t want;
  } dir_step_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i;
  logic [1:0]  cfg_idx_i;
  logic [15:0] cfg_data_i;

  sgl_req_if glyph_req ();
  sgl_rsp_if glyph_rsp ();

  scaled_glyph_line_renderer_unit #(
    .LINE_PIXELS(LinePixels),
    .STORE_ROWS (StoreRows)
  ) DUT (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .req_i     (glyph_req),
    .rsp_o     (glyph_rsp)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // mirror of the block state
  logic [15:0] line_mirror [StoreWords];
  logic [15:0] fg_word = FgReset;
  logic [15:0] bg_word = BgReset;
  logic [7:0]  scale_q = ScaleReset;
  logic        drawing_on = 1'b0;
  logic [8:0]  held_row = '0;
  bit          store_touched = 1'b0;

  glyph_rsp_t  reply_q [$];
  int unsigned mismatches = 0;
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct = 0;

  // kind     bits      row    wid    xoff    start    addr       typed pixel     row     act
  dir_step_t steps [22] = '{
    {ReqEnd,   16'h0000, 4'd0,  5'd0,  8'd0,   9'd0,   13'd0,    1'b1, 16'h0000, 9'd0,   1'b0},
    {ReqSpare, 16'hFFFF, 4'd15, 5'd31, 8'd255, 9'd511, 13'd8191, 1'b0, 16'h0000, 9'd0,   1'b0},
    {ReqDraw,  16'hFFFF, 4'd0,  5'd16, 8'd0,   9'd319, 13'd0,    1'b0, 16'h0000, 9'd0,   1'b0},
    {ReqRead,  16'h0000, 4'd0,  5'd0,  8'd0,   9'd0,   13'd0,    1'b1, 16'hFFFF, 9'd0,   1'b0},
    {ReqRead,  16'h0000, 4'd0,  5'd0,  8'd0,   9'd0,   13'd15,   1'b1, 16'hFFFF, 9'd0,   1'b0},
    {ReqRead,  16'h0000, 4'd0,  5'd0,  8'd0,   9'd0,   13'd16,   1'b1, 16'h0000, 9'd0,   1'b0},
    {ReqDraw,  16'h0000, 4'd1,  5'd31, 8'd239, 9'd0,   13'd0,    1'b0, 16'h0000, 9'd0,   1'b0},
    {ReqRead,  16'h0000, 4'd0,  5'd0,  8'd0,   9'd0,   13'd480,  1'b0, 16'h0000, 9'd0,   1'b0},
    {ReqDraw,  16'hA5A5, 4'd2,  5'd0,  8'd5,   9'd0,   13'd0,    1'b0, 16'h0000, 9'd0,   1'b0},
    {ReqDraw,  16'h8001, 4'd15, 5'd16, 8'd255, 9'd0,   13'd0,    1'b0, 16'h0000, 9'd0,   1'b0},
    {ReqRead,  16'h0000, 4'd0,  5'd0,  8'd0,   9'd0,   13'd3855, 1'b0, 16'h0000, 9'd0,   1'b0},
    {ReqRead,  16'h0000, 4'd0,  5'd0,  8'd0,   9'd0,   13'd3870, 1'b0, 16'h0000, 9'd0,   1'b0},
    {ReqRead,  16'h0000, 4'd0,  5'd0,  8'd0,   9'd0,   13'd8191, 1'b1, 16'h0000, 9'd0,   1'b0},
    {ReqRead,  16'h0000, 4'd0,  5'd0,  8'd0,   9'd0,   13'd7679, 1'b0, 16'h0000, 9'd0,   1'b0},
    {ReqEnd,   16'h0000, 4'd0,  5'd0,  8'd0,   9'd0,   13'd0,    1'b1, 16'h0000, 9'd319, 1'b1},
    {ReqEnd,   16'h0000, 4'd0,  5'd0,  8'd0,   9'd0,   13'd0,    1'b1, 16'h0000, 9'd319, 1'b0},
    {ReqDraw,  16'h1234, 4'd0,  5'd8,  8'd100, 9'd0,   13'd0,    1'b0, 16'h0000, 9'd0,   1'b0},
    {ReqRead,  16'h0000, 4'd0,  5'd0,  8'd0,   9'd0,   13'd103,  1'b0, 16'h0000, 9'd0,   1'b0},
    {ReqRead,  16'h0000, 4'd0,  5'd0,  8'd0,   9'd0,   13'd3855, 1'b0, 16'h0000, 9'd0,   1'b0},
    {ReqDraw,  16'hFFFF, 4'd1,  5'd16, 8'd224, 9'd511, 13'd0,    1'b0, 16'h0000, 9'd0,   1'b0},
    {ReqRead,  16'h0000, 4'd0,  5'd0,  8'd0,   9'd0,   13'd479,  1'b0, 16'h0000, 9'd0,   1'b0},
    {ReqEnd,   16'h0000, 4'd0,  5'd0,  8'd0,   9'd0,   13'd0,    1'b1, 16'h0000, 9'd0,   1'b1}
  };

  function automatic int unsigned scaled(int unsigned k);
    return (k * scale_q) >> 4;
  endfunction

  function automatic void paint_row(logic [15:0] bits, logic [3:0] row, logic [4:0] width,
                                    logic [7:0] xoff);
    int unsigned w, y, i, x, base, addr;
    logic [15:0] color;
    w = (width > GlyphBits) ? GlyphBits : width;
    for (y = scaled(row); y < scaled(row + 1); y++) begin
      base = y * LinePixels + xoff;
      for (i = 0; i < w; i++) begin
        color = bits[15 - i] ? fg_word : bg_word;
        for (x = scaled(i); x < scaled(i + 1); x++) begin
          addr = base + x;
          // linear addressing: columns past the line spill into the next row
          if (addr < StoreWords) line_mirror[addr] = color;
        end
      end
    end
  endfunction

  // updates the mirror for one accepted request; returns 1 when a response is due
  function automatic bit mirror_request(input glyph_req_t rq, output glyph_rsp_t rsp);
    int unsigned k;
    rsp = '0;
    case (rq.kind)
      ReqDraw: begin
        if (!drawing_on) begin
          drawing_on = 1'b1;
          held_row = rq.start;
          for (k = 0; k < StoreWords; k++) line_mirror[k] = '0;
          store_touched = 1'b1;
        end
        paint_row(rq.bits, rq.row, rq.width, rq.xoff);
        return 1'b0;
      end
      ReqRead: begin
        if (rq.addr < StoreWords) rsp.pixel = line_mirror[rq.addr];
        return 1'b1;
      end
      ReqEnd: begin
        rsp.row = held_row;
        rsp.active = drawing_on;
        drawing_on = 1'b0;
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  function automatic glyph_req_t random_request(logic [1:0] kind);
    glyph_req_t rq;
    rq.kind  = kind;
    rq.bits  = 16'($urandom);
    rq.row   = 4'($urandom);
    rq.width = 5'($urandom_range(16, 1));
    rq.xoff  = 8'($urandom);
    rq.start = 9'($urandom);
    rq.addr  = 13'($urandom);
    return rq;
  endfunction

  // mostly lands inside the span just painted by glyph row r
  function automatic logic [12:0] aim_read(int unsigned r, int unsigned xo, int unsigned gw);
    int unsigned y0, y1, span, y, x;
    y0 = scaled(r);
    y1 = scaled(r + 1);
    span = scaled((gw > GlyphBits) ? GlyphBits : gw);
    if (y1 > y0 && $urandom_range(9) < 8) begin
      y = $urandom_range(y1 - 1, y0);
      x = xo + $urandom_range(span, 0);
      return 13'(y * LinePixels + x);
    end
    return 13'($urandom_range(8191, 0));
  endfunction

  task automatic log_mismatch(input string what, input logic [15:0] got,
                              input logic [15:0] want);
    $display("mismatch at %0t: %s got %0h want %0h", $realtime, what, got, want);
    mismatches++;
  endtask

  task automatic offer_request(input glyph_req_t rq, input logic typed,
                               input glyph_rsp_t want);
    glyph_rsp_t predicted;
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      glyph_req.valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    glyph_req.valid       <= 1'b1;
    glyph_req.req_type    <= rq.kind;
    glyph_req.row_bits    <= rq.bits;
    glyph_req.row_index   <= rq.row;
    glyph_req.glyph_width <= rq.width;
    glyph_req.x_offset    <= rq.xoff;
    glyph_req.start_row   <= rq.start;
    glyph_req.read_addr   <= rq.addr;
    @(posedge clk_i);
    while (!glyph_req.ready) @(posedge clk_i);
    if (mirror_request(rq, predicted)) reply_q.push_back(typed ? want : predicted);
  endtask

  task automatic set_idling(input int unsigned mode);
    case (mode)
      1:       begin send_idle_pct = 62; stall_pct = 0;  end
      2:       begin send_idle_pct = 0;  stall_pct = 62; end
      3:       begin send_idle_pct = 37; stall_pct = 37; end
      default: begin send_idle_pct = 0;  stall_pct = 0;  end
    endcase
  endtask

  task automatic load_settings(input logic [15:0] fg, input logic [15:0] bg,
                               input logic [7:0] sc);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CfgFgColor;
    cfg_data_i <= fg;
    @(posedge clk_i);
    cfg_idx_i  <= CfgBgColor;
    cfg_data_i <= bg;
    @(posedge clk_i);
    cfg_idx_i  <= CfgScale;
    cfg_data_i <= {8'h00, sc};
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    fg_word = fg;
    bg_word = bg;
    scale_q = sc;
  endtask

  // every phase closes with an end request, so an empty queue means the block is idle
  task automatic settle();
    while (reply_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic random_phase(input int unsigned quota);
    int unsigned done, rows, gw, xo, r, n, pick;
    glyph_req_t rq;
    done = 0;
    while (done < quota) begin
      pick = $urandom_range(99);
      if (pick < 85) begin
        // well-formed glyph: rows in order, reads of the painted area, then end
        rows = $urandom_range(16, 1);
        if (scale_q > 64 && $urandom_range(9) != 0) gw = $urandom_range(4, 1);
        else gw = $urandom_range(16, 1);
        if ($urandom_range(19) == 0) gw = $urandom_range(31, 0);
        xo = ($urandom_range(3) == 0) ? $urandom_range(255, 0) : $urandom_range(224, 0);
        for (r = 0; r < rows; r++) begin
          rq = random_request(ReqDraw);
          rq.row = 4'(r);
          rq.width = 5'(gw);
          rq.xoff = 8'(xo);
          offer_request(rq, 1'b0, '0);
          done++;
          for (n = $urandom_range(2, 0); n != 0; n--) begin
            rq = random_request(ReqRead);
            rq.addr = aim_read(r, xo, gw);
            offer_request(rq, 1'b0, '0);
            done++;
          end
        end
        offer_request(random_request(ReqEnd), 1'b0, '0);
        done++;
      end else begin
        case (pick % 4)
          0: offer_request(random_request(ReqSpare), 1'b0, '0);
          1: begin
            offer_request(random_request(ReqEnd), 1'b0, '0);
            done++;
          end
          2: if (store_touched) begin
            offer_request(random_request(ReqRead), 1'b0, '0);
            done++;
          end
          default: begin
            // stray row out of order, any width the field allows (at most 4 at large scales)
            rq = random_request(ReqDraw);
            rq.width = 5'($urandom);
            if (scale_q > 64) rq.width = 5'($urandom_range(4, 0));
            offer_request(rq, 1'b0, '0);
            done++;
          end
        endcase
      end
    end
    offer_request(random_request(ReqEnd), 1'b0, '0);
    glyph_req.valid <= 1'b0;
  endtask

  always @(posedge clk_i) begin
    glyph_rsp.ready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk_i) begin : reply_check
    glyph_rsp_t want;
    if (rst_ni && glyph_rsp.valid && glyph_rsp.ready) begin
      if (reply_q.size() == 0) begin
        log_mismatch("response with none pending", glyph_rsp.pixel, '0);
      end else begin
        want = reply_q.pop_front();
        if (glyph_rsp.pixel !== want.pixel)
          log_mismatch("pixel", glyph_rsp.pixel, want.pixel);
        if (glyph_rsp.latched_row !== want.row)
          log_mismatch("latched_row", 16'(glyph_rsp.latched_row), 16'(want.row));
        if (glyph_rsp.was_active !== want.active)
          log_mismatch("was_active", 16'(glyph_rsp.was_active), 16'(want.active));
      end
    end
  end

  initial begin : stimulus
    int unsigned ph;
    logic [15:0] fg, bg;
    logic [7:0]  sc;
    glyph_req.valid       <= 1'b0;
    glyph_req.req_type    <= ReqDraw;
    glyph_req.row_bits    <= '0;
    glyph_req.row_index   <= '0;
    glyph_req.glyph_width <= '0;
    glyph_req.x_offset    <= '0;
    glyph_req.start_row   <= '0;
    glyph_req.read_addr   <= '0;
    cfg_we_i              <= 1'b0;
    cfg_idx_i             <= CfgFgColor;
    cfg_data_i            <= '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (3) @(posedge clk_i);

    set_idling(0);
    foreach (steps[n]) offer_request(steps[n].rq, steps[n].typed, steps[n].want);
    glyph_req.valid <= 1'b0;
    settle();

    for (ph = 0; ph < 8; ph++) begin
      set_idling(ph % 4);
      fg = 16'($urandom);
      bg = 16'($urandom);
      case (ph)
        0:       begin fg = 16'hFFFF; bg = 16'h0000; sc = 8'd16; end
        1:       begin fg = 16'h0000; bg = 16'hFFFF; sc = 8'd32; end
        2:       sc = 8'd1;
        3:       sc = 8'd255;
        4:       sc = 8'd24;
        5:       sc = 8'($urandom_range(255, 1));
        6:       sc = 8'd8;
        default: sc = 8'($urandom_range(48, 1));
      endcase
      load_settings(fg, bg, sc);
      random_phase(125);
      settle();
    end

    repeat (50) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin : watchdog
    #100_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule
